@@ hdl/qet_pkg.sv @@
// Shared types and constants of the quoted, escaped byte tokenizer.
`default_nettype none

package qet_pkg;

  localparam int unsigned CharW       = 8;
  localparam int unsigned DelimWordW  = 64;
  localparam int unsigned NumDelimWds = 4;
  localparam int unsigned DelimMapW   = DelimWordW * NumDelimWds;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 64;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DELIM_MAP_0 = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DELIM_MAP_1 = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DELIM_MAP_2 = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DELIM_MAP_3 = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ALLOW_EMPTY = 3'd4;

  // special bytes
  localparam logic [CharW-1:0] CH_NUL    = 8'h00;
  localparam logic [CharW-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CharW-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CharW-1:0] CH_N      = 8'h6E;
  localparam logic [CharW-1:0] CH_T      = 8'h74;
  localparam logic [CharW-1:0] CH_R      = 8'h72;
  localparam logic [CharW-1:0] CH_LF     = 8'h0A;
  localparam logic [CharW-1:0] CH_TAB    = 8'h09;
  localparam logic [CharW-1:0] CH_CR     = 8'h0D;

  // results produced by one byte
  localparam logic [1:0] NRES_NONE = 2'd0;
  localparam logic [1:0] NRES_ONE  = 2'd1;
  localparam logic [1:0] NRES_TWO  = 2'd2;

  typedef struct packed {
    logic             has_char;
    logic [CharW-1:0] char_out;
    logic             token_end;
    logic             text_end;
    logic             last_of_run;
  } qet_res_t;

  typedef struct packed {
    logic token_open;
    logic quoted;
    logic esc;
  } qet_state_t;

  typedef struct packed {
    logic [1:0] num_res;
    qet_res_t   res0;
    qet_state_t nxt;
  } qet_dec_t;

  // second result of a trailing delimiter with empty tokens kept
  localparam qet_res_t TRAIL_EMPTY_RES = '{
    has_char:    1'b0,
    char_out:    '0,
    token_end:   1'b1,
    text_end:    1'b1,
    last_of_run: 1'b1
  };

endpackage

`default_nettype wire

@@ hdl/qet_in_if.sv @@
// Input byte channel of the tokenizer.
`default_nettype none

interface qet_in_if;
  logic                    valid;
  logic                    ready;
  logic [qet_pkg::CharW-1:0] char_in;
  logic                    last_byte;

  modport source (output valid, output char_in, output last_byte, input ready);
  modport sink   (input valid, input char_in, input last_byte, output ready);
endinterface

`default_nettype wire

@@ hdl/qet_out_if.sv @@
// Result channel of the tokenizer.
`default_nettype none

interface qet_out_if;
  logic                    valid;
  logic                    ready;
  logic                    has_char;
  logic [qet_pkg::CharW-1:0] char_out;
  logic                    token_end;
  logic                    text_end;
  logic                    last_of_run;

  modport source (output valid, output has_char, output char_out, output token_end,
                  output text_end, output last_of_run, input ready);
  modport sink   (input valid, input has_char, input char_out, input token_end,
                  input text_end, input last_of_run, output ready);
endinterface

`default_nettype wire

@@ hdl/qet_cfg_if.sv @@
// Configuration write channel of the tokenizer.
`default_nettype none

interface qet_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [qet_pkg::CfgIdxW-1:0]  index;
  logic [qet_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/qet_cfg_regs.sv @@
// Configuration registers: delimiter map and allow-empty flag.
`default_nettype none

module qet_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  qet_cfg_if.sink                           cfg,
  output logic [qet_pkg::DelimMapW-1:0]     delim_map_o,
  output logic                              allow_empty_o
);
  import qet_pkg::*;

  logic [NumDelimWds-1:0][DelimWordW-1:0] map_q;
  logic                                   allow_empty_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q         <= '0;
      allow_empty_q <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_DELIM_MAP_0: map_q[0] <= cfg.data[DelimWordW-1:0];
        CFG_DELIM_MAP_1: map_q[1] <= cfg.data[DelimWordW-1:0];
        CFG_DELIM_MAP_2: map_q[2] <= cfg.data[DelimWordW-1:0];
        CFG_DELIM_MAP_3: map_q[3] <= cfg.data[DelimWordW-1:0];
        CFG_ALLOW_EMPTY: allow_empty_q <= cfg.data[0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign delim_map_o   = map_q;
  assign allow_empty_o = allow_empty_q;

endmodule

`default_nettype wire

@@ hdl/qet_decode.sv @@
// Per-byte decode: delimiter lookup, quote/escape handling, next state.
`default_nettype none

module qet_decode (
  input  wire logic [qet_pkg::CharW-1:0]     char_i,
  input  wire logic                          last_i,
  input  wire qet_pkg::qet_state_t           state_i,
  input  wire logic [qet_pkg::DelimMapW-1:0] delim_map_i,
  input  wire logic                          allow_empty_i,
  output qet_pkg::qet_dec_t                  dec_o
);
  import qet_pkg::*;

  logic             is_delim;
  logic             eff_quoted;
  logic             eff_esc;
  logic             has;
  logic [CharW-1:0] ch;
  logic             emit;

  assign is_delim   = delim_map_i[char_i];
  // a byte that opens a token starts with clean quote/escape state
  assign eff_quoted = state_i.token_open & state_i.quoted;
  assign eff_esc    = state_i.token_open & state_i.esc;

  always_comb begin
    dec_o   = '0;
    has     = 1'b0;
    ch      = '0;
    emit    = 1'b0;

    if (!state_i.token_open && is_delim) begin
      // delimiter between tokens: skipped, or opens an empty token; a last byte also ends the text
      dec_o.nxt.token_open = allow_empty_i;
      if (last_i) begin
        dec_o.num_res        = NRES_ONE;
        dec_o.res0.token_end = allow_empty_i;
        dec_o.res0.text_end  = 1'b1;
      end
    end else begin
      dec_o.nxt.token_open = 1'b1;
      dec_o.nxt.quoted     = eff_quoted;
      if (eff_esc) begin
        case (char_i)
          CH_N:    begin has = 1'b1; ch = CH_LF;  end
          CH_T:    begin has = 1'b1; ch = CH_TAB; end
          CH_R:    begin has = 1'b1; ch = CH_CR;  end
          CH_NUL:  has = 1'b0;
          default: begin has = 1'b1; ch = char_i; end
        endcase
        emit = has | last_i;
      end else if (is_delim && !eff_quoted) begin
        // closes the token; with empty tokens kept a new one opens
        dec_o.nxt.token_open = allow_empty_i;
        dec_o.nxt.quoted     = 1'b0;
        dec_o.num_res        = (last_i && allow_empty_i) ? NRES_TWO : NRES_ONE;
        dec_o.res0.token_end = 1'b1;
        dec_o.res0.text_end  = last_i & ~allow_empty_i;
      end else if (char_i == CH_QUOTE) begin
        dec_o.nxt.quoted = ~eff_quoted;
        emit             = last_i;
      end else if (char_i == CH_BSLASH) begin
        dec_o.nxt.esc = 1'b1;
        emit          = last_i;
      end else begin
        has  = 1'b1;
        ch   = char_i;
        emit = 1'b1;
      end

      if (emit) begin
        dec_o.num_res        = NRES_ONE;
        dec_o.res0.has_char  = has;
        dec_o.res0.char_out  = ch;
        dec_o.res0.token_end = last_i;
        dec_o.res0.text_end  = last_i;
      end
    end

    dec_o.res0.last_of_run = (dec_o.num_res == NRES_ONE);
    if (last_i) begin
      dec_o.nxt = '0;  // text ends: next byte starts fresh
    end
  end

endmodule

`default_nettype wire

@@ hdl/quoted_escaped_tokenizer.sv @@
// Top level of the quoted, escaped byte tokenizer.
//
//  channel | dir | payload                                          | request when
//  --------+-----+--------------------------------------------------+------------------
//  in_i    | in  | char_in[7:0], last_byte                          | valid & ready
//  out_o   | out | has_char, char_out[7:0], token_end, text_end,    | valid & ready
//          |     | last_of_run                                      |
//  cfg_i   | in  | index[2:0], data[63:0]                           | valid & ready
//
//  One byte per cycle sustained while the output accepts results. A byte is held
//  in the input register, is decoded there and its first result lands in the
//  output register. A trailing delimiter with empty tokens kept yields two results;
//  the second follows the first through the output register, holding input for it.
//  Bytes that yield nothing retire even while the output is stalled.
//  Reset clears the tokenizer state, the delimiter map and the allow-empty flag;
//  config is always ready and takes effect on the next decoded byte.
`default_nettype none

module quoted_escaped_tokenizer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  qet_in_if.sink    in_i,
  qet_out_if.source out_o,
  qet_cfg_if.sink   cfg_i
);
  import qet_pkg::*;

  // configuration
  logic [DelimMapW-1:0] delim_map;
  logic                 allow_empty;

  // input register
  logic             in_vld_q;
  logic [CharW-1:0] in_char_q;
  logic             in_last_q;

  // tokenizer state
  qet_state_t state_q;

  // output register plus a flag for the queued second result
  logic     out_vld_q;
  qet_res_t out_res_q;
  logic     pend_q;

  qet_dec_t dec;
  logic     slot_free;
  logic     consume;
  logic     in_req;
  logic     out_req;

  qet_cfg_regs u_cfg_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg           (cfg_i),
    .delim_map_o   (delim_map),
    .allow_empty_o (allow_empty)
  );

  qet_decode u_decode (
    .char_i        (in_char_q),
    .last_i        (in_last_q),
    .state_i       (state_q),
    .delim_map_i   (delim_map),
    .allow_empty_i (allow_empty),
    .dec_o         (dec)
  );

  // output slot is free if empty or draining with nothing queued behind it
  assign slot_free = !out_vld_q || (out_o.ready && !pend_q);
  assign consume   = in_vld_q && ((dec.num_res == NRES_NONE) || slot_free);
  assign in_i.ready = !in_vld_q || consume;
  assign in_req     = in_i.valid && in_i.ready;
  assign out_req    = out_vld_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_req) begin
      in_vld_q <= 1'b1;
    end else if (consume) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_req) begin
      in_char_q <= in_i.char_in;
      in_last_q <= in_i.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (consume) begin
      state_q <= dec.nxt;
    end
  end

  // a new result only loads when the slot is free, so it never meets a
  // queued second result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      pend_q    <= 1'b0;
    end else if (consume && dec.num_res != NRES_NONE) begin
      out_vld_q <= 1'b1;
      pend_q    <= (dec.num_res == NRES_TWO);
    end else if (out_req) begin
      if (pend_q) begin
        pend_q <= 1'b0;
      end else begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && dec.num_res != NRES_NONE) begin
      out_res_q <= dec.res0;
    end else if (out_req && pend_q) begin
      out_res_q <= TRAIL_EMPTY_RES;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.has_char    = out_res_q.has_char;
  assign out_o.char_out    = out_res_q.char_out;
  assign out_o.token_end   = out_res_q.token_end;
  assign out_o.text_end    = out_res_q.text_end;
  assign out_o.last_of_run = out_res_q.last_of_run;

  // a queued second result always sits behind a valid first one
  a_pend_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> out_vld_q)
    else $error("second result queued without a result in the output register");

  // the queued result is the trailing empty token
  a_pend_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && out_o.ready) |=>
      (out_vld_q && out_o.token_end && out_o.text_end && !out_o.has_char &&
       out_o.last_of_run && !pend_q))
    else $error("trailing empty token malformed");

  // quote or escape state only lives inside an open token
  a_state_in_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.quoted || state_q.esc) |-> state_q.token_open)
    else $error("quote or escape state outside a token");

  // last byte of a text clears all tokenizer state
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && in_last_q) |=> (state_q == '0))
    else $error("state not cleared at end of text");

  // a valid result with no second one queued behind it must end the run
  a_single_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !pend_q) |-> out_o.last_of_run)
    else $error("last result of a byte lacks last_of_run");

endmodule

`default_nettype wire
